FILE: rtl/ntlv_pkg.sv
`timescale 1ns / 1ps
package ntlv_pkg;

	// Done item status codes
	localparam logic [1:0] ST_FOUND    = 2'd0;
	localparam logic [1:0] ST_NONE     = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	// TLV type and length marker bytes
	localparam logic [7:0] TYPE_PAD     = 8'h00;
	localparam logic [7:0] TYPE_MESSAGE = 8'h03;
	localparam logic [7:0] TYPE_TERM    = 8'hFE;
	localparam logic [7:0] LEN_LONG     = 8'hFF;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_DONE    = 1'b1;

	// Configuration register indexes
	localparam logic REG_AREA_SIZE_CODE  = 1'b0;
	localparam logic REG_OUTPUT_CAPACITY = 1'b1;

	localparam logic [15:0] CAPACITY_RESET = 16'd960;

	// Action queue between parser and emitter
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef struct packed {
		logic       first;
		logic [7:0] area_byte;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload_byte;
		logic [1:0] status;
		logic [9:0] message_length;
		logic       last;
	} out_item_t;

	// One parsed byte's work for the emitter
	typedef struct packed {
		logic       has_byte;
		logic [7:0] data;
		logic       has_done;
		logic [1:0] status;
		logic [9:0] length;
	} action_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

FILE: rtl/ntlv_front.sv
`timescale 1ns / 1ps
module ntlv_front #(
	parameter int MAX_AREA = 960
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              accept,
	input  ntlv_pkg::in_item_t item,
	output logic              act_valid,
	output ntlv_pkg::action_t act
);

	localparam int AW = $clog2(MAX_AREA + 1);
	localparam logic [11:0] MAX12 = 12'(MAX_AREA);
	localparam logic [AW-1:0] MAX_AW = AW'(MAX_AREA);

	localparam logic [2:0] PH_TYPE    = 3'd0;
	localparam logic [2:0] PH_LEN     = 3'd1;
	localparam logic [2:0] PH_LENHI   = 3'd2;
	localparam logic [2:0] PH_LENLO   = 3'd3;
	localparam logic [2:0] PH_SKIP    = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;
	localparam logic [2:0] PH_DONE    = 3'd6;

	logic [7:0]    area_code_q;
	logic [15:0]   cap_q;
	logic [2:0]    phase_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] area_q;
	logic          ndef_q;
	logic [7:0]    len_hi_q;
	logic [15:0]   left_q;
	logic [9:0]    found_q;

	logic [11:0]   size_raw;
	logic [AW-1:0] new_area;
	logic [2:0]    eff_phase;
	logic [AW-1:0] eff_pos;
	logic [AW-1:0] eff_area;
	logic          eff_ndef;
	logic [7:0]    eff_len_hi;
	logic [15:0]   eff_left;
	logic [9:0]    eff_found;
	logic [AW-1:0] pos_n;
	logic          at_end;
	logic [AW-1:0] rem;
	logic [15:0]   rem16;
	logic [15:0]   len_w;
	logic [15:0]   len_clip;
	logic          do_resolve;
	logic [7:0]    b;

	logic [2:0]    nxt_phase;
	logic [AW-1:0] nxt_pos;
	logic          nxt_ndef;
	logic [7:0]    nxt_len_hi;
	logic [15:0]   nxt_left;
	logic [9:0]    nxt_found;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_code_q <= 8'd0;
			cap_q       <= ntlv_pkg::CAPACITY_RESET;
		end else if (cfg_we) begin
			if (cfg_index == ntlv_pkg::REG_AREA_SIZE_CODE) begin
				area_code_q <= cfg_data[7:0];
			end else begin
				cap_q <= cfg_data;
			end
		end
	end

	// Restart state on a first byte, then parse the byte
	always_comb begin
		b        = item.area_byte;
		size_raw = {1'b0, area_code_q, 3'b000};
		if (size_raw == 12'd0 || size_raw > MAX12) begin
			new_area = MAX_AW;
		end else begin
			new_area = size_raw[AW-1:0];
		end

		eff_phase  = item.first ? PH_TYPE : phase_q;
		eff_pos    = item.first ? '0 : pos_q;
		eff_area   = item.first ? new_area : area_q;
		eff_ndef   = item.first ? 1'b0 : ndef_q;
		eff_len_hi = item.first ? 8'd0 : len_hi_q;
		eff_left   = item.first ? 16'd0 : left_q;
		eff_found  = item.first ? 10'd0 : found_q;

		pos_n    = eff_pos + AW'(1);
		at_end   = (pos_n >= eff_area);
		rem      = (eff_area > pos_n) ? (eff_area - pos_n) : '0;
		rem16    = 16'(rem);
		len_w    = (eff_phase == PH_LENLO) ? {eff_len_hi, b} : {8'd0, b};
		len_clip = (len_w > rem16) ? rem16 : len_w;

		nxt_phase  = eff_phase;
		nxt_pos    = eff_pos;
		nxt_ndef   = eff_ndef;
		nxt_len_hi = eff_len_hi;
		nxt_left   = eff_left;
		nxt_found  = eff_found;
		do_resolve = 1'b0;
		act_valid  = 1'b0;
		act        = '0;

		if (!(eff_phase == PH_DONE || eff_pos >= eff_area)) begin
			nxt_pos = pos_n;
			case (eff_phase)
				PH_TYPE: begin
					if (b == ntlv_pkg::TYPE_TERM) begin
						act.has_done = 1'b1;
						act.status   = ntlv_pkg::ST_NONE;
					end else if (b == ntlv_pkg::TYPE_PAD) begin
						if (at_end) begin
							act.has_done = 1'b1;
							act.status   = ntlv_pkg::ST_NONE;
						end
					end else begin
						nxt_ndef = (b == ntlv_pkg::TYPE_MESSAGE);
						if (at_end) begin
							act.has_done = 1'b1;
							act.status   = ntlv_pkg::ST_NONE;
						end else begin
							nxt_phase = PH_LEN;
						end
					end
				end
				PH_LEN: begin
					if (b == ntlv_pkg::LEN_LONG) begin
						if (at_end) begin
							act.has_done = 1'b1;
							act.status   = ntlv_pkg::ST_NONE;
						end else begin
							nxt_phase = PH_LENHI;
						end
					end else begin
						do_resolve = 1'b1;
					end
				end
				PH_LENHI: begin
					nxt_len_hi = b;
					if (at_end) begin
						act.has_done = 1'b1;
						act.status   = ntlv_pkg::ST_NONE;
					end else begin
						nxt_phase = PH_LENLO;
					end
				end
				PH_LENLO: begin
					do_resolve = 1'b1;
				end
				PH_SKIP: begin
					nxt_left = eff_left - 16'd1;
					if (nxt_left == 16'd0) begin
						nxt_phase = PH_TYPE;
					end
				end
				PH_PAYLOAD: begin
					act.has_byte = 1'b1;
					act.data     = b;
					nxt_left     = eff_left - 16'd1;
					if (nxt_left == 16'd0) begin
						act.has_done = 1'b1;
						act.status   = ntlv_pkg::ST_FOUND;
						act.length   = eff_found;
					end
				end
				default: begin
					nxt_phase = PH_DONE;
				end
			endcase

			// Resolve a complete TLV length
			if (do_resolve) begin
				if (eff_ndef) begin
					if (len_clip > cap_q) begin
						act.has_done = 1'b1;
						act.status   = ntlv_pkg::ST_OVERFLOW;
					end else begin
						nxt_found = len_clip[9:0];
						if (len_clip == 16'd0) begin
							act.has_done = 1'b1;
							act.status   = ntlv_pkg::ST_FOUND;
						end else begin
							nxt_left  = len_clip;
							nxt_phase = PH_PAYLOAD;
						end
					end
				end else if (len_w >= rem16 && (len_w != 16'd0 || rem16 == 16'd0)) begin
					act.has_done = 1'b1;
					act.status   = ntlv_pkg::ST_NONE;
				end else if (len_w == 16'd0) begin
					nxt_phase = PH_TYPE;
				end else begin
					nxt_left  = len_w;
					nxt_phase = PH_SKIP;
				end
			end

			if (act.has_done) begin
				nxt_phase = PH_DONE;
			end
			act_valid = accept && (act.has_byte || act.has_done);
		end
	end

	// Advance parse state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			pos_q    <= '0;
			area_q   <= MAX_AW;
			ndef_q   <= 1'b0;
			len_hi_q <= 8'd0;
			left_q   <= 16'd0;
			found_q  <= 10'd0;
		end else if (accept) begin
			phase_q  <= nxt_phase;
			pos_q    <= nxt_pos;
			area_q   <= eff_area;
			ndef_q   <= nxt_ndef;
			len_hi_q <= nxt_len_hi;
			left_q   <= nxt_left;
			found_q  <= nxt_found;
		end
	end

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !item.first && phase_q == PH_DONE) |-> !act_valid)
		else $error("item after done produced a result");

	a_byte_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(act_valid && act.has_byte) |-> (item.first == 1'b0 && phase_q == PH_PAYLOAD))
		else $error("payload byte outside payload phase");

	a_area_range: assert property (@(posedge clk) disable iff (!arst_n)
		(area_q != '0) && (area_q <= MAX_AW))
		else $error("area size out of range");

	a_done_sets_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(act_valid && act.has_done) |=> (phase_q == PH_DONE))
		else $error("done item without done phase");

endmodule

FILE: rtl/ntlv_queue.sv
`timescale 1ns / 1ps
module ntlv_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  ntlv_pkg::action_t    wr_data,
	input  logic                 rd_en,
	output ntlv_pkg::action_t    rd_data,
	output ntlv_pkg::q_status_t  stat
);

	localparam int AW = ntlv_pkg::QAW;

	ntlv_pkg::action_t mem [ntlv_pkg::QDEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_wr;
	logic          do_rd;

	assign stat.full  = (count_q == (AW + 1)'(ntlv_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_data    = mem[rd_ptr_q];

	// Store pushed actions
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (AW + 1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (AW + 1)'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW + 1)'(ntlv_pkg::QDEPTH))
		else $error("queue occupancy beyond depth");

endmodule

FILE: rtl/ntlv_back.sv
`timescale 1ns / 1ps
module ntlv_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ntlv_pkg::action_t   head,
	input  logic                q_empty,
	output logic                deq,
	output ntlv_pkg::out_item_t result,
	output logic                empty,
	input  logic                pop
);

	ntlv_pkg::out_item_t out_q;
	logic                out_valid_q;
	logic                sub_q;
	logic                slot_free;
	logic                load;
	logic                take_byte;
	ntlv_pkg::out_item_t item_n;

	assign empty     = !out_valid_q;
	assign result    = out_q;
	assign slot_free = !out_valid_q || pop;
	assign load      = slot_free && !q_empty;
	assign take_byte = head.has_byte && !sub_q;
	assign deq       = load && (!take_byte || !head.has_done);

	// Build the next result item from the head action
	always_comb begin
		item_n = '0;
		if (take_byte) begin
			item_n.kind         = ntlv_pkg::KIND_PAYLOAD;
			item_n.payload_byte = head.data;
		end else begin
			item_n.kind           = ntlv_pkg::KIND_DONE;
			item_n.status         = head.status;
			item_n.message_length = (head.status == ntlv_pkg::ST_FOUND) ? head.length : 10'd0;
			item_n.last           = 1'b1;
		end
	end

	// Hold the output register until popped
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= item_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sub_q       <= take_byte && head.has_done;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_sub_only_split: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> (!q_empty && head.has_byte && head.has_done))
		else $error("split flag set without a two-result action");

endmodule

FILE: rtl/ndef_tlv_message_extractor_top.sv
`timescale 1ns / 1ps
// NDEF TLV extractor for a Type 2 tag data area. Push one data-area byte per cycle; full
// rises only when the four-entry action queue between the parser and the result emitter
// fills. Each accepted byte is parsed in the cycle it is taken, and a byte that causes a
// payload byte and the done item together gives two result items, the payload byte first.
// Results come out through a queue-like port: read result while empty is low and pulse
// pop to take it. Every parse ends with one done item carrying status and, for a found
// message, the clipped length; later bytes give nothing until the next byte with first
// set. Write configuration only while the block is idle.
module ndef_tlv_message_extractor_top #(
	parameter int MAX_AREA = 960
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	input  ntlv_pkg::in_item_t  byte_item,
	input  logic                push,
	output logic                full,
	output ntlv_pkg::out_item_t result,
	output logic                empty,
	input  logic                pop
);

	logic                accept;
	logic                act_valid;
	ntlv_pkg::action_t   act;
	ntlv_pkg::action_t   head;
	ntlv_pkg::q_status_t q_stat;
	logic                deq;

	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;

	// Parse and classify incoming bytes
	ntlv_front #(
		.MAX_AREA (MAX_AREA)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (byte_item),
		.act_valid (act_valid),
		.act       (act)
	);

	// Decouple parser from emitter
	ntlv_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (act_valid),
		.wr_data (act),
		.rd_en   (deq),
		.rd_data (head),
		.stat    (q_stat)
	);

	// Emit result items
	ntlv_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_stat.empty),
		.deq     (deq),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule
